>>> design/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg: shared constants and types for the flat shading pipeline
// Field widths, internal datapath widths, register indexes and
// pipeline depths used by the top level and the normalize unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

    // Port field widths
    localparam int COORD_W    = 16;
    localparam int UNIT_W     = 16;
    localparam int INTEN_W    = 15;
    localparam int MAT_W      = 9;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Internal datapath widths
    localparam int EDGE_W  = COORD_W + 1;        // b-a, c-a
    localparam int LDIR_W  = COORD_W + 3;        // 3*light - (a+b+c)
    localparam int PROD_W  = 2 * EDGE_W;         // edge products
    localparam int VEC_W   = PROD_W + 2;         // cross product components
    localparam int POS_W   = $clog2(VEC_W);      // leading one position
    localparam int MAG_W   = 30;                 // normalized magnitude
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;          // one root bit per step
    localparam int REM_W   = ROOT_W + 3;
    localparam int FRAC_W  = 14;                 // Q1.14
    localparam int NUM_W   = MAG_W + FRAC_W + 2;
    localparam int QUO_W   = 16;                 // one quotient bit per step
    localparam int DP_W    = 2 * UNIT_W;
    localparam int DOT_W   = DP_W + 2;
    localparam int MPROD_W = MAT_W + INTEN_W;

    // Pipeline depths
    localparam int NORM_LAT = 4 + ROOT_W + QUO_W + 1;
    localparam int PIPE_LEN = 3 + NORM_LAT + 3;

    localparam logic [UNIT_W-1:0]  ONE_Q14   = UNIT_W'(16384);
    localparam logic [MAT_W-1:0]   MAT_RESET = MAT_W'(256);
    localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(255);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAT_R   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MAT_G   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MAT_B   = CFG_IDX_W'(5);

    typedef logic signed [VEC_W-1:0]  vcomp_t;
    typedef logic signed [UNIT_W-1:0] ucomp_t;

endpackage

`default_nettype wire

>>> design/fst_norm.sv
// ----------------------------------------------------------------------------
// fst_norm: pipelined unit vector in Q1.14
// Scales the largest magnitude into [2^29, 2^30), takes the length by a
// digit-per-stage square root and divides each component by a
// bit-per-stage restoring divider. A zero vector gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_norm (
    input  logic           clk,
    input  logic           en,
    input  fst_pkg::vcomp_t vec_in [3],
    output fst_pkg::ucomp_t unit_out [3]
);
    import fst_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0]            x;
        logic [REM_W-1:0]            r;
        logic [ROOT_W-1:0]           root;
        logic [2:0][MAG_W-1:0]       mag;
        logic [2:0]                  neg;
        logic                        zero;
    } sqst_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0]       rem;
        logic [ROOT_W-1:0]           len;
        logic [2:0][QUO_W-1:0]       q;
        logic [2:0]                  neg;
        logic                        zero;
    } dvst_t;

    // Stage 0: magnitudes, signs and the largest magnitude
    logic [VEC_W-1:0] abs0 [3];
    logic [VEC_W-1:0] top0;
    logic [VEC_W-1:0] mag0_reg [3];
    logic [2:0]       neg0_reg;
    logic [VEC_W-1:0] top0_reg;

    always_comb
    begin
        top0 = '0;
        for (int i = 0; i < 3; i++)
        begin
            abs0[i] = vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : VEC_W'(vec_in[i]);
            if (abs0[i] > top0)
            begin
                top0 = abs0[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag0_reg[i] <= abs0[i];
                neg0_reg[i] <= vec_in[i][VEC_W-1];
            end
            top0_reg <= top0;
        end
    end

    // Stage 1: shift all components so the largest has its top bit at 29
    logic [POS_W-1:0]         pos1;
    logic [VEC_W+MAG_W-2:0]   wide1 [3];
    logic [MAG_W-1:0]         mag1_reg [3];
    logic [2:0]               neg1_reg;
    logic                     zero1_reg;

    always_comb
    begin
        pos1 = '0;
        for (int k = 0; k < VEC_W; k++)
        begin
            if (top0_reg[k])
            begin
                pos1 = POS_W'(k);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            wide1[i] = {mag0_reg[i], (MAG_W-1)'(0)} >> pos1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= wide1[i][MAG_W-1:0];
            end
            neg1_reg  <= neg0_reg;
            zero1_reg <= (top0_reg == '0);
        end
    end

    // Stage 2: squares
    logic [SQ_W-1:0]  sq2_reg [3];
    logic [MAG_W-1:0] mag2_reg [3];
    logic [2:0]       neg2_reg;
    logic             zero2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i]  <= SQ_W'(mag1_reg[i]) * SQ_W'(mag1_reg[i]);
                mag2_reg[i] <= mag1_reg[i];
            end
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // Stage 3: sum of squares
    logic [SUM_W-1:0] sum3_reg;
    logic [MAG_W-1:0] mag3_reg [3];
    logic [2:0]       neg3_reg;
    logic             zero3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum3_reg  <= SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // Square root: one root bit per stage
    sqst_t sq_reg  [ROOT_W];
    sqst_t sq_next [ROOT_W];
    sqst_t sq_src;
    logic [REM_W-1:0] r_sh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        sq_src = '0;
        r_sh   = '0;
        trial  = '0;
        for (int j = 0; j < ROOT_W; j++)
        begin
            if (j == 0)
            begin
                sq_src      = '0;
                sq_src.x    = sum3_reg;
                sq_src.mag  = {mag3_reg[2], mag3_reg[1], mag3_reg[0]};
                sq_src.neg  = neg3_reg;
                sq_src.zero = zero3_reg;
            end
            else
            begin
                sq_src = sq_reg[j-1];
            end
            r_sh  = {sq_src.r[REM_W-3:0], sq_src.x[SUM_W-1-2*j -: 2]};
            trial = {1'b0, sq_src.root, 2'b01};
            sq_next[j] = sq_src;
            if (r_sh >= trial)
            begin
                sq_next[j].r    = r_sh - trial;
                sq_next[j].root = {sq_src.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[j].r    = r_sh;
                sq_next[j].root = {sq_src.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < ROOT_W; j++)
            begin
                sq_reg[j] <= sq_next[j];
            end
        end
    end

    // Division: one quotient bit per stage, rounded by adding len/2 first
    dvst_t dv_reg  [QUO_W];
    dvst_t dv_next [QUO_W];
    dvst_t dv_src;
    logic [NUM_W-1:0] cmp;
    sqst_t sq_last;

    always_comb
    begin
        sq_last = sq_reg[ROOT_W-1];
        dv_src  = '0;
        cmp     = '0;
        for (int k = 0; k < QUO_W; k++)
        begin
            if (k == 0)
            begin
                dv_src      = '0;
                dv_src.len  = sq_last.root;
                dv_src.neg  = sq_last.neg;
                dv_src.zero = sq_last.zero;
                for (int i = 0; i < 3; i++)
                begin
                    dv_src.rem[i] = (NUM_W'(sq_last.mag[i]) << FRAC_W)
                                    + NUM_W'(sq_last.root >> 1);
                end
            end
            else
            begin
                dv_src = dv_reg[k-1];
            end
            cmp = NUM_W'(dv_src.len) << (QUO_W - 1 - k);
            dv_next[k] = dv_src;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_src.rem[i] >= cmp)
                begin
                    dv_next[k].rem[i]              = dv_src.rem[i] - cmp;
                    dv_next[k].q[i][QUO_W - 1 - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // Final stage: cap at one, restore sign, force zero vector
    dvst_t            dv_last;
    logic [QUO_W-1:0] qcap [3];
    ucomp_t           unit_next [3];
    ucomp_t           unit_reg  [3];

    always_comb
    begin
        dv_last = dv_reg[QUO_W-1];
        for (int i = 0; i < 3; i++)
        begin
            qcap[i] = (dv_last.q[i] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : dv_last.q[i];
            if (dv_last.zero)
            begin
                unit_next[i] = '0;
            end
            else if (dv_last.neg[i])
            begin
                unit_next[i] = ucomp_t'(-qcap[i]);
            end
            else
            begin
                unit_next[i] = ucomp_t'(qcap[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
        end
    end

    assign unit_out = unit_reg;

endmodule

`default_nettype wire

>>> design/flat_shade_triangle.sv
// Throughput: one triangle per cycle while the skid word is empty; each square root and divide step is its own stage.
// A two-word output buffer (output register plus skid) lets the pipeline keep moving
// after out_ready drops until one more word arrives; in_ready then follows the skid state.
// Reset clears all valid bits, sets the light to the origin and the materials to 1.0.
// ----------------------------------------------------------------------------
// flat_shade_triangle: flat Lambert shading of one triangle
// Face normal from the edge cross product, light direction from the
// centroid, clamped dot product as intensity, material-scaled color.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_shade_triangle (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fst_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_a_x,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_a_y,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_a_z,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_b_x,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_b_y,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_b_z,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_c_x,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_c_y,
    input  logic signed [fst_pkg::COORD_W-1:0] vertex_c_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [fst_pkg::UNIT_W-1:0] normal_x,
    output logic signed [fst_pkg::UNIT_W-1:0] normal_y,
    output logic signed [fst_pkg::UNIT_W-1:0] normal_z,
    output logic [fst_pkg::INTEN_W-1:0]      intensity,
    output logic [fst_pkg::COLOR_W-1:0]      color_red,
    output logic [fst_pkg::COLOR_W-1:0]      color_green,
    output logic [fst_pkg::COLOR_W-1:0]      color_blue
);
    import fst_pkg::*;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0]  nrm;
        logic [INTEN_W-1:0]      inten;
        logic [2:0][COLOR_W-1:0] col;
    } res_t;

    // Configuration registers
    logic signed [COORD_W-1:0] light_reg [3];
    logic [MAT_W-1:0]          mat_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                light_reg[i] <= '0;
                mat_reg[i]   <= MAT_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LIGHT_X: light_reg[0] <= cfg_data;
                REG_LIGHT_Y: light_reg[1] <= cfg_data;
                REG_LIGHT_Z: light_reg[2] <= cfg_data;
                REG_MAT_R:   mat_reg[0]   <= cfg_data[MAT_W-1:0];
                REG_MAT_G:   mat_reg[1]   <= cfg_data[MAT_W-1:0];
                REG_MAT_B:   mat_reg[2]   <= cfg_data[MAT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Pipeline advance and valid bits
    logic                en;
    logic [PIPE_LEN-1:0] vld_reg;
    logic                skid_v_reg;

    assign en       = ~skid_v_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], in_valid};
        end
    end

    // Stage T0: edges and light direction
    logic signed [COORD_W-1:0] av [3];
    logic signed [COORD_W-1:0] bv [3];
    logic signed [COORD_W-1:0] cv [3];
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [LDIR_W-1:0]  ld0_reg [3];

    assign av[0] = vertex_a_x;
    assign av[1] = vertex_a_y;
    assign av[2] = vertex_a_z;
    assign bv[0] = vertex_b_x;
    assign bv[1] = vertex_b_y;
    assign bv[2] = vertex_b_z;
    assign cv[0] = vertex_c_x;
    assign cv[1] = vertex_c_y;
    assign cv[2] = vertex_c_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]  <= EDGE_W'(bv[i]) - EDGE_W'(av[i]);
                e2_reg[i]  <= EDGE_W'(cv[i]) - EDGE_W'(av[i]);
                ld0_reg[i] <= (LDIR_W'(light_reg[i]) <<< 1) + LDIR_W'(light_reg[i])
                              - LDIR_W'(av[i]) - LDIR_W'(bv[i]) - LDIR_W'(cv[i]);
            end
        end
    end

    // Stage T1: cross product terms
    logic signed [PROD_W-1:0] pr_reg [6];
    logic signed [LDIR_W-1:0] ld1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            pr_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            pr_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            pr_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            pr_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            pr_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
            ld1_reg   <= ld0_reg;
        end
    end

    // Stage T2: cross product components
    vcomp_t cr_reg [3];
    vcomp_t ld2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i]  <= VEC_W'(pr_reg[2*i]) - VEC_W'(pr_reg[2*i+1]);
                ld2_reg[i] <= VEC_W'(ld1_reg[i]);
            end
        end
    end

    // Normalize face normal and light direction side by side
    ucomp_t nrm [3];
    ucomp_t lgt [3];

    fst_norm u_norm_face (
        .clk      (clk),
        .en       (en),
        .vec_in   (cr_reg),
        .unit_out (nrm)
    );

    fst_norm u_norm_light (
        .clk      (clk),
        .en       (en),
        .vec_in   (ld2_reg),
        .unit_out (lgt)
    );

    // Stage T3: dot product terms
    logic signed [DP_W-1:0] dp_reg [3];
    ucomp_t                 n3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i] <= DP_W'(nrm[i]) * DP_W'(lgt[i]);
            end
            n3_reg <= nrm;
        end
    end

    // Stage T4: clamp, round and saturate intensity
    logic signed [DOT_W-1:0] dot4;
    logic [DOT_W-FRAC_W-1:0] rnd4;
    logic [INTEN_W-1:0]      inten_next;
    logic [INTEN_W-1:0]      inten4_reg;
    ucomp_t                  n4_reg [3];

    always_comb
    begin
        dot4 = DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
        rnd4 = (DOT_W-FRAC_W)'((dot4 + DOT_W'(1 << (FRAC_W - 1))) >>> FRAC_W);
        if (dot4 <= 0)
        begin
            inten_next = '0;
        end
        else if (rnd4 > (DOT_W-FRAC_W)'(ONE_Q14))
        begin
            inten_next = INTEN_W'(ONE_Q14);
        end
        else
        begin
            inten_next = rnd4[INTEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inten4_reg <= inten_next;
            n4_reg     <= n3_reg;
        end
    end

    // Stage T5: material times intensity
    logic [MPROD_W-1:0] mp_reg [3];
    logic [INTEN_W-1:0] inten5_reg;
    ucomp_t             n5_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mp_reg[i] <= MPROD_W'(mat_reg[i]) * MPROD_W'(inten4_reg);
            end
            inten5_reg <= inten4_reg;
            n5_reg     <= n4_reg;
        end
    end

    // Scale by 255, round and saturate colors
    localparam int SC_W = MPROD_W + 9;
    logic [SC_W-1:0] sc  [3];
    logic [SC_W-23:0] cq [3];
    res_t inc_d;
    logic incoming;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sc[i] = (SC_W'(mp_reg[i]) << 8) - SC_W'(mp_reg[i]) + SC_W'(1 << 21);
            cq[i] = sc[i][SC_W-1:22];
            inc_d.col[i] = (cq[i] > (SC_W-22)'(COLOR_MAX)) ? COLOR_MAX : cq[i][COLOR_W-1:0];
            inc_d.nrm[i] = n5_reg[i];
        end
        inc_d.inten = inten5_reg;
    end

    assign incoming = en & vld_reg[PIPE_LEN-1];

    // Output register and skid word
    logic out_v_reg;
    logic out_v_next;
    logic skid_v_next;
    res_t out_d_reg;
    res_t out_d_next;
    res_t skid_d_reg;
    res_t skid_d_next;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        out_d_next  = out_d_reg;
        skid_d_next = skid_d_reg;
        if (!out_v_reg || out_ready)
        begin
            out_v_next  = skid_v_reg | incoming;
            out_d_next  = skid_v_reg ? skid_d_reg : inc_d;
            skid_v_next = 1'b0;
        end
        else if (incoming)
        begin
            skid_v_next = 1'b1;
            skid_d_next = inc_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign out_valid   = out_v_reg;
    assign normal_x    = out_d_reg.nrm[0];
    assign normal_y    = out_d_reg.nrm[1];
    assign normal_z    = out_d_reg.nrm[2];
    assign intensity   = out_d_reg.inten;
    assign color_red   = out_d_reg.col[0];
    assign color_green = out_d_reg.col[1];
    assign color_blue  = out_d_reg.col[2];

endmodule

`default_nettype wire
